/* design/abls_pkg.sv */
`timescale 1ns / 1ps

package abls_pkg;

   localparam int LINE_Y_W = 33;
   localparam int AREA_W   = 64;

   typedef struct packed {
      logic [15:0] bottom_y;
      logic [15:0] side;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [LINE_Y_W-1:0] line_y;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start_iter;
      logic pass_step;
      logic decide;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic narrow;
      logic pass_last;
      logic pipe_busy;
      logic out_ready;
   } status_type;

endpackage

/* design/abls_ram.sv */
`timescale 1ns / 1ps

module abls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/abls_dp.sv */
`timescale 1ns / 1ps

module abls_dp
   import abls_pkg::*;
#(
   parameter int MAX_SQUARES = 1024,
   parameter int COORD_BITS  = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   localparam int AW      = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
   localparam int CNT_W   = $clog2(MAX_SQUARES + 1);
   localparam int LINE_W  = (COORD_BITS + 1 + FRAC_BITS > LINE_Y_W) ?
                            (COORD_BITS + 1 + FRAC_BITS) : LINE_Y_W;
   localparam int DIFF_W  = COORD_BITS + FRAC_BITS;
   localparam int PROD_W  = DIFF_W + COORD_BITS;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [LINE_W-1:0]     lo_ff, lo_in;
   logic [LINE_W-1:0]     hi_ff, hi_in;
   logic [LINE_W-1:0]     k_ff, k_in;
   logic [AREA_W-1:0]     total_ff, total_in;
   logic [AREA_W-1:0]     below_ff, below_in;
   logic                  ovf_ff, ovf_in;

   // Three-stage pass pipeline: RAM read, operand select, multiply.
   logic                  v1_ff, v2_ff, v3_ff;
   logic                  tot2_ff, tot3_ff;
   logic [DIFF_W-1:0]     opa_ff, opa_in;
   logic [COORD_BITS-1:0] ops_ff, ops_in;
   logic [PROD_W-1:0]     prod_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [COORD_BITS-1:0] in_b, in_s, rd_b, rd_s;
   logic [LINE_W-1:0]     in_bf, in_tf, rd_bf, rd_tf, span;
   logic                  room, store_en;

   assign in_b     = COORD_BITS'(req_payload.bottom_y);
   assign in_s     = COORD_BITS'(req_payload.side);
   assign in_bf    = LINE_W'(in_b) << FRAC_BITS;
   assign in_tf    = (LINE_W'(in_b) + LINE_W'(in_s)) << FRAC_BITS;
   assign room     = (count_ff != CNT_W'(MAX_SQUARES));
   assign store_en = cmd.load && room;

   abls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SQUARES)) u_bottom_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (in_b),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_b)
   );

   abls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SQUARES)) u_side_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (in_s),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_s)
   );

   assign rd_bf = LINE_W'(rd_b) << FRAC_BITS;
   assign rd_tf = (LINE_W'(rd_b) + LINE_W'(rd_s)) << FRAC_BITS;
   assign span  = hi_ff - lo_ff;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      total_in = total_ff;
      below_in = below_ff;
      ovf_in   = ovf_ff;
      opa_in   = '0;
      ops_in   = '0;

      if (store_en) begin
         count_in = count_ff + CNT_W'(1);
         if (in_bf < lo_ff) begin
            lo_in = in_bf;
         end
         if (in_tf > hi_ff) begin
            hi_in = in_tf;
         end
      end else if (cmd.load) begin
         ovf_in = 1'b1;
      end

      // The multiplier is shared: a loaded square forms side squared for the
      // total, a stored square forms its share of the area below the line.
      if (store_en) begin
         opa_in = DIFF_W'(in_s) << FRAC_BITS;
         ops_in = in_s;
      end else if (v1_ff) begin
         ops_in = rd_s;
         if (rd_tf <= k_ff) begin
            opa_in = DIFF_W'(rd_s) << FRAC_BITS;
         end else if (rd_bf < k_ff) begin
            // A straddling square has k - bottom below side, so it fits.
            opa_in = DIFF_W'(k_ff - rd_bf);
         end
      end

      if (v3_ff) begin
         if (tot3_ff) begin
            total_in = total_ff + AREA_W'(prod_ff);
         end else begin
            below_in = below_ff + AREA_W'(prod_ff);
         end
      end

      if (cmd.start_iter) begin
         k_in     = lo_ff + (span >> 1);
         below_in = '0;
         idx_in   = '0;
      end
      if (cmd.pass_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.decide) begin
         if (total_ff > (below_ff << 1)) begin
            lo_in = k_ff;
         end else begin
            hi_in = k_ff;
         end
      end

      if (cmd.emit) begin
         count_in = '0;
         lo_in    = LINE_W'({LINE_Y_W{1'b1}});
         hi_in    = '0;
         total_in = '0;
         below_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         lo_ff        <= LINE_W'({LINE_Y_W{1'b1}});
         hi_ff        <= '0;
         total_ff     <= '0;
         below_ff     <= '0;
         ovf_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         tot2_ff      <= 1'b0;
         tot3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         total_ff <= total_in;
         below_ff <= below_in;
         ovf_ff   <= ovf_in;
         v1_ff    <= cmd.pass_step;
         v2_ff    <= (store_en || v1_ff) && !cmd.emit;
         tot2_ff  <= store_en;
         v3_ff    <= v2_ff && !cmd.emit;
         tot3_ff  <= tot2_ff;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      opa_ff  <= opa_in;
      ops_ff  <= ops_in;
      prod_ff <= PROD_W'(opa_ff) * PROD_W'(ops_ff);
      if (cmd.emit) begin
         rsp_ff.line_y   <= status.empty ? '0 : lo_ff[LINE_Y_W-1:0];
         rsp_ff.overflow <= ovf_ff;
      end
   end

   assign status.empty     = (count_ff == '0) || (lo_ff > hi_ff);
   assign status.narrow    = (span <= LINE_W'(1));
   assign status.pass_last = (idx_ff == count_ff - CNT_W'(1));
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign status.out_ready = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SQUARES))
      else $error("square count exceeds the store depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pass_step |-> (idx_ff < count_ff))
      else $error("pass reads beyond the stored squares");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> !(v1_ff || v2_ff || v3_ff))
      else $error("bound update before the area sum settled");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0) && !ovf_ff && rsp_valid_ff)
      else $error("set not cleared after a result");

endmodule

/* design/abls_ctrl.sv */
`timescale 1ns / 1ps

module abls_ctrl
   import abls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_PASS   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.empty || status.narrow) begin
               state_in = S_DONE;
            end else begin
               cmd.start_iter = 1'b1;
               state_in       = S_PASS;
            end
         end
         S_PASS: begin
            cmd.pass_step = 1'b1;
            if (status.pass_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_CHECK;
         end
         S_DONE: begin
            if (status.out_ready) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start_iter, cmd.pass_step, cmd.decide, cmd.emit}))
      else $error("more than one datapath command in a cycle");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && req_last) |=> (state_ff == S_CHECK))
      else $error("final square did not start the search");

   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.pass_step && status.pass_last) |=> (state_ff == S_DRAIN))
      else $error("pass did not stop at the last stored square");

endmodule

/* design/area_bisecting_line_search_top.sv */
`timescale 1ns / 1ps

// Squares load at one request per cycle into two on-chip stores of
// MAX_SQUARES entries. A request marked last starts a binary search for the
// horizontal line that splits the summed area evenly; the input is stalled
// until the result has been placed in the output register. Each search
// iteration streams every stored square through one shared multiplier, and
// the search needs one iteration per bit of (highest top - lowest bottom) in
// fixed point, about log2(span) + FRAC_BITS iterations. A set with no stored
// squares answers 0. Squares beyond MAX_SQUARES are dropped and reported in
// the overflow bit of the set's result.
module area_bisecting_line_search_top
   import abls_pkg::*;
#(
   parameter int MAX_SQUARES = 1024,
   parameter int COORD_BITS  = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   abls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abls_dp #(
      .MAX_SQUARES (MAX_SQUARES),
      .COORD_BITS  (COORD_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* dv/tb_area_bisecting_line_search_top.sv */
`timescale 1ns / 1ps

module tb_area_bisecting_line_search_top
   import abls_pkg::*;
();

   localparam int STORE_DEPTH = 1024;
   localparam int FRAC = 16;
   localparam logic [63:0] LOW_START = 64'h1_FFFF_FFFF;

   typedef struct packed {
      logic [15:0]         bottom_y;
      logic [15:0]         side;
      logic                last;
      logic                known;
      logic [LINE_Y_W-1:0] line_y;
   } plan_row_type;

   // Rows marked known carry a line that follows directly from one square, or
   // from identical squares: the emitted line is one LSB under the exact half (the bottom if side is 0).
   localparam int PLAN_LEN = 18;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{16'd0,      16'd1,      1'b1, 1'b1, 33'd32767},
      '{16'd65535,  16'd65535,  1'b1, 1'b1, 33'd6442352639},
      '{16'd0,      16'd65535,  1'b1, 1'b1, 33'd2147450879},
      '{16'd65535,  16'd1,      1'b1, 1'b1, 33'd4294934527},
      '{16'd1234,   16'd0,      1'b1, 1'b1, 33'd80871424},
      '{16'd0,      16'd0,      1'b0, 1'b0, 33'd0},
      '{16'd10,     16'd4,      1'b1, 1'b0, 33'd0},
      '{16'd5,      16'd10,     1'b0, 1'b0, 33'd0},
      '{16'd5,      16'd10,     1'b1, 1'b1, 33'd655359},
      '{16'd0,      16'd2,      1'b0, 1'b0, 33'd0},
      '{16'd100,    16'd2,      1'b1, 1'b0, 33'd0},
      '{16'hAAAA,   16'h5555,   1'b0, 1'b0, 33'd0},
      '{16'h5555,   16'hAAAA,   1'b1, 1'b0, 33'd0},
      '{16'hFFFF,   16'hFFFF,   1'b0, 1'b0, 33'd0},
      '{16'd0,      16'd1,      1'b0, 1'b0, 33'd0},
      '{16'd300,    16'd7,      1'b0, 1'b0, 33'd0},
      '{16'd0,      16'hFFFF,   1'b1, 1'b0, 33'd0},
      '{16'd7,      16'd3,      1'b1, 1'b1, 33'd557055}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Predicted state of the current set of squares.
   logic [15:0] kept_bottom [STORE_DEPTH];
   logic [15:0] kept_side [STORE_DEPTH];
   int          kept_count = 0;
   logic [63:0] span_low = LOW_START;
   logic [63:0] span_high = '0;
   logic [63:0] area_total = '0;
   bit          dropped = 1'b0;

   rsp_type expected_lines [$];
   int      bad_results = 0;
   bit      quiet = 1'b0;
   int      hold_left = 0;

   area_bisecting_line_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] area_under(input logic [63:0] k);
      logic [63:0] acc;
      logic [63:0] b;
      logic [63:0] s;
      logic [63:0] bf;
      logic [63:0] tf;
      acc = '0;
      for (int i = 0; i < kept_count; i++) begin
         b = 64'(kept_bottom[i]);
         s = 64'(kept_side[i]);
         bf = b << FRAC;
         tf = (b + s) << FRAC;
         if (tf <= k) begin
            acc += (s * s) << FRAC;
         end else if (bf < k) begin
            acc += (k - bf) * s;
         end
      end
      return acc;
   endfunction

   function automatic void absorb_square(input req_type sq);
      logic [63:0] s;
      logic [63:0] bf;
      logic [63:0] tf;
      s = 64'(sq.side);
      bf = 64'(sq.bottom_y) << FRAC;
      tf = (64'(sq.bottom_y) + s) << FRAC;
      if (kept_count < STORE_DEPTH) begin
         kept_bottom[kept_count] = sq.bottom_y;
         kept_side[kept_count] = sq.side;
         kept_count++;
         if (bf < span_low) span_low = bf;
         if (tf > span_high) span_high = tf;
         area_total += (s * s) << FRAC;
      end else begin
         dropped = 1'b1;
      end
   endfunction

   function automatic rsp_type close_set();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      rsp_type     res;
      lo = span_low;
      hi = span_high;
      res.overflow = dropped;
      res.line_y = '0;
      if (kept_count != 0 && lo <= hi) begin
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (area_total > area_under(mid) * 2) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         res.line_y = lo[LINE_Y_W-1:0];
      end
      kept_count = 0;
      span_low = LOW_START;
      span_high = '0;
      area_total = '0;
      dropped = 1'b0;
      return res;
   endfunction

   task automatic send_square(input logic [15:0] bottom_y, input logic [15:0] side,
                              input logic last, input logic known,
                              input logic [LINE_Y_W-1:0] typed_line);
      int      gap;
      req_type sq;
      rsp_type want;
      gap = quiet ? 0 : $urandom_range(0, 4);
      sq = '{bottom_y: bottom_y, side: side, last: last};
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= sq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_square(sq);
      if (last) begin
         want = close_set();
         if (known) begin
            want.line_y = typed_line;
            want.overflow = 1'b0;
         end
         expected_lines.push_back(want);
      end
   endtask

   // The stall drawn after each result is held until the next result has
   // waited out the drawn length.
   always @(posedge clock) begin : collect
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("unexpected result: line_y %0d overflow %0b",
                           rsp_payload.line_y, rsp_payload.overflow);
            end else begin
               want = expected_lines.pop_front();
               if (rsp_payload.line_y !== want.line_y ||
                   rsp_payload.overflow !== want.overflow) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display("mismatch: line_y exp %0d got %0d, overflow exp %0b got %0b",
                              want.line_y, rsp_payload.line_y,
                              want.overflow, rsp_payload.overflow);
               end
            end
            hold_left = quiet ? 0 : $urandom_range(0, 4);
         end else if (rsp_valid && hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   initial begin
      int          set_no;
      int          set_size;
      int          mode;
      int          pick;
      int          small_items;
      logic [15:0] b;
      logic [15:0] s;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i])
         send_square(PLAN[i].bottom_y, PLAN[i].side, PLAN[i].last, PLAN[i].known,
                     PLAN[i].line_y);

      small_items = 0;
      set_no = 0;
      while (small_items < 800) begin
         quiet = ($urandom_range(0, 3) == 0);
         // One set fills the store and then drops two squares, the second of
         // which carries last.
         if (set_no == 40) begin
            for (int j = 0; j < STORE_DEPTH + 2; j++)
               send_square(16'($urandom), 16'($urandom), j == STORE_DEPTH + 1, 1'b0, '0);
         end
         mode = $urandom_range(0, 3);
         pick = $urandom_range(0, 19);
         if (pick < 14) set_size = $urandom_range(1, 4);
         else if (pick < 19) set_size = $urandom_range(5, 16);
         else set_size = $urandom_range(17, 64);
         for (int j = 0; j < set_size; j++) begin
            case (mode)
               0: begin
                  b = 16'($urandom);
                  s = 16'($urandom);
               end
               1: begin
                  b = 16'($urandom_range(0, 255));
                  s = 16'($urandom_range(1, 64));
               end
               2: begin
                  b = 16'($urandom_range(65000, 65535));
                  s = 16'($urandom_range(60000, 65535));
               end
               default: begin
                  b = 16'($urandom_range(0, 1000));
                  s = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
               end
            endcase
            send_square(b, s, j == set_size - 1, 1'b0, '0);
            small_items++;
         end
         set_no++;
      end

      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (bad_results == 0 && expected_lines.size() == 0) begin
         $display("tb_area_bisecting_line_search_top passed");
      end else begin
         $display("tb_area_bisecting_line_search_top failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_area_bisecting_line_search_top failed");
      $finish;
   end

endmodule
